FILE: rtl/core/integer_to_text_formatter_core_defines.svh
// Assertion macros for the integer to text formatter.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef INTEGER_TO_TEXT_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_TO_TEXT_FORMATTER_CORE_DEFINES_SVH

// Same-cycle implication.
`define ITF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ITF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/itf_pkg.sv
// ----------------------------------------------------------------------------
// itf_pkg
// Types and constants shared by the integer to text formatter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package itf_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         op;
    logic [5:0]         digits_wanted;
  } itf_in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       empty_res;
  } itf_out_t;

  // format codes
  localparam logic [2:0] OP_DEC = 3'd0;
  localparam logic [2:0] OP_FIX = 3'd1;
  localparam logic [2:0] OP_HEX = 3'd2;
  localparam logic [2:0] OP_CHR = 3'd3;

  // conversion source
  localparam logic CONV_SRC_INT  = 1'b0;
  localparam logic CONV_SRC_FRAC = 1'b1;

  // counter load selection
  localparam logic [1:0] CNT_PAD  = 2'd0;
  localparam logic [1:0] CNT_DIG  = 2'd1;
  localparam logic [1:0] CNT_FRAC = 2'd2;
  localparam logic [1:0] CNT_HEX  = 2'd3;

  // character selection
  localparam logic [2:0] CH_SIGN  = 3'd0;
  localparam logic [2:0] CH_ZERO  = 3'd1;
  localparam logic [2:0] CH_DIGIT = 3'd2;
  localparam logic [2:0] CH_DOT   = 3'd3;
  localparam logic [2:0] CH_FRAC  = 3'd4;
  localparam logic [2:0] CH_HEX   = 3'd5;
  localparam logic [2:0] CH_BYTE  = 3'd6;
  localparam logic [2:0] CH_EMPTY = 3'd7;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_DOT   = 8'h2E;
  localparam logic [7:0] ASCII_A     = 8'h41;

  localparam logic [16:0] FRAC_SCALE  = 17'd100000;
  localparam logic [5:0]  FRAC_DIGITS = 6'd5;
  localparam logic [5:0]  HEX_DIGITS  = 6'd8;
  localparam int          CONV_BITS   = 5;   // 32 shift-add-3 steps

  typedef struct packed {
    logic       load;
    logic       conv_start;
    logic       conv_src;
    logic       conv_step;
    logic       cnt_load;
    logic [1:0] cnt_sel;
    logic       cnt_dec;
    logic       frac_shift;
    logic       emit;
    logic [2:0] char_sel;
    logic       last;
  } itf_cmd_t;

  typedef struct packed {
    logic       conv_last;
    logic       cnt_one;
    logic       neg;
    logic       pad_nz;
    logic [2:0] op;
    logic       out_free;
  } itf_sts_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) ch = ASCII_ZERO + {4'd0, nib};
    else ch = ASCII_A + {4'd0, nib} - 8'd10;
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/itf_dpath.sv
// ----------------------------------------------------------------------------
// itf_dpath
// Operand registers, shift-add-3 binary to BCD converter, character counter
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "integer_to_text_formatter_core_defines.svh"

module itf_dpath
  import itf_pkg::*;
#(
  parameter int MAX_PRECISION = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire itf_in_t  in_data,
  input  wire logic     out_ready,
  output logic          out_valid,
  output itf_out_t      out_data,
  input  wire itf_cmd_t cmd,
  output itf_sts_t      sts
);

  localparam logic [5:0] MAX_PREC6 = 6'(MAX_PRECISION);

  logic [31:0]          val_r;
  logic [2:0]           op_r;
  logic [5:0]           prec_r;
  logic [16:0]          frac_r;
  logic [31:0]          bin_r;
  logic [9:0][3:0]      bcd_r;
  logic [CONV_BITS-1:0] conv_cnt_r;
  logic [5:0]           cnt_r;
  logic                 out_valid_r;
  itf_out_t             out_data_r;

  logic [32:0]     frac_prod;
  logic [31:0]     dec_mag;
  logic [16:0]     fix_mag;
  logic [31:0]     conv_load_val;
  logic [9:0][3:0] bcd_adj;
  logic [40:0]     dd_wide;
  logic [3:0]      ndig;
  logic [5:0]      prec_eff;
  logic [5:0]      pad_cnt;
  logic [5:0]      hex_n;
  logic [5:0]      frac_n;
  logic [5:0]      cnt_load_val;
  logic [3:0]      dig_idx;
  logic [2:0]      hex_idx;
  logic [7:0][3:0] val_nib;
  logic [7:0]      char_val;
  logic            out_free;

  assign frac_prod = 33'(in_data.value[15:0]) * 33'(FRAC_SCALE);

  assign dec_mag = val_r[31] ? (32'd0 - val_r) : val_r;
  // floor of a negative 16.16 value: print 0x10000 minus the upper half
  assign fix_mag = val_r[31] ? (17'h10000 - {1'b0, val_r[31:16]}) : {1'b0, val_r[31:16]};

  always_comb begin
    if (cmd.conv_src == CONV_SRC_FRAC) conv_load_val = {15'd0, frac_r};
    else if (op_r == OP_DEC) conv_load_val = dec_mag;
    else conv_load_val = {15'd0, fix_mag};
  end

  // one double-dabble step
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? (bcd_r[i] + 4'd3) : bcd_r[i];
    end
  end
  assign dd_wide = {bcd_adj, bin_r[31]};

  always_comb begin
    ndig = 4'd1;
    for (int i = 1; i < 10; i++) begin
      if (bcd_r[i] != 4'd0) ndig = 4'(i + 1);
    end
  end

  assign prec_eff = (prec_r > MAX_PREC6) ? MAX_PREC6 : prec_r;
  assign pad_cnt  = (prec_eff > {2'd0, ndig}) ? (prec_eff - {2'd0, ndig}) : 6'd0;
  assign hex_n    = (prec_r == 6'd0 || prec_r > HEX_DIGITS) ? HEX_DIGITS : prec_r;
  assign frac_n   = (prec_r == 6'd0 || prec_r > FRAC_DIGITS) ? FRAC_DIGITS : prec_r;

  always_comb begin
    unique case (cmd.cnt_sel)
      CNT_PAD:  cnt_load_val = pad_cnt;
      CNT_DIG:  cnt_load_val = {2'd0, ndig};
      CNT_FRAC: cnt_load_val = frac_n;
      CNT_HEX:  cnt_load_val = hex_n;
      default:  cnt_load_val = 6'd0;
    endcase
  end

  assign dig_idx = 4'(cnt_r - 6'd1);
  assign hex_idx = 3'(cnt_r - 6'd1);
  assign val_nib = val_r;

  always_comb begin
    unique case (cmd.char_sel)
      CH_SIGN:  char_val = ASCII_MINUS;
      CH_ZERO:  char_val = ASCII_ZERO;
      CH_DIGIT: char_val = ASCII_ZERO | {4'd0, bcd_r[dig_idx]};
      CH_DOT:   char_val = ASCII_DOT;
      CH_FRAC:  char_val = ASCII_ZERO | {4'd0, bcd_r[4]};
      CH_HEX:   char_val = hex_char(val_nib[hex_idx]);
      CH_BYTE:  char_val = val_r[7:0];
      CH_EMPTY: char_val = 8'd0;
      default:  char_val = 8'd0;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r  <= in_data.value;
      op_r   <= in_data.op;
      prec_r <= in_data.digits_wanted;
      frac_r <= frac_prod[32:16];
    end

    if (cmd.conv_start) begin
      bin_r      <= conv_load_val;
      bcd_r      <= '0;
      conv_cnt_r <= '0;
    end else if (cmd.conv_step) begin
      bin_r      <= {bin_r[30:0], 1'b0};
      bcd_r      <= dd_wide[39:0];
      conv_cnt_r <= conv_cnt_r + 1'b1;
    end else if (cmd.frac_shift) begin
      bcd_r <= {bcd_r[8:0], 4'd0};
    end

    if (cmd.cnt_load) cnt_r <= cnt_load_val;
    else if (cmd.cnt_dec) cnt_r <= cnt_r - 6'd1;

    if (cmd.emit) begin
      out_data_r.character <= char_val;
      out_data_r.last      <= cmd.last;
      out_data_r.empty_res <= (cmd.char_sel == CH_EMPTY);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.conv_last = (conv_cnt_r == {CONV_BITS{1'b1}});
  assign sts.cnt_one   = (cnt_r == 6'd1);
  assign sts.neg       = val_r[31];
  assign sts.pad_nz    = (pad_cnt != 6'd0);
  assign sts.op        = op_r;
  assign sts.out_free  = out_free;

  `ITF_ASSERT_NOW(a_empty_is_last, out_valid_r && out_data_r.empty_res, out_data_r.last,
    "empty marker not flagged as last")

endmodule

`default_nettype wire

FILE: rtl/core/itf_ctrl.sv
// ----------------------------------------------------------------------------
// itf_ctrl
// Sequencer: dispatches on the format, runs the BCD conversions and steps
// through sign, padding, digits, dot and fraction characters, hex digits or a single byte.
// ----------------------------------------------------------------------------
`default_nettype none
`include "integer_to_text_formatter_core_defines.svh"

module itf_ctrl
  import itf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output itf_cmd_t      cmd,
  input  wire itf_sts_t sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_CONV  = 4'd2;
  localparam logic [3:0] S_NUM   = 4'd3;
  localparam logic [3:0] S_SIGN  = 4'd4;
  localparam logic [3:0] S_PAD   = 4'd5;
  localparam logic [3:0] S_DIG   = 4'd6;
  localparam logic [3:0] S_DOT   = 4'd7;
  localparam logic [3:0] S_CONV2 = 4'd8;
  localparam logic [3:0] S_FRAC  = 4'd9;
  localparam logic [3:0] S_HEX   = 4'd10;
  localparam logic [3:0] S_ONE   = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic [3:0] num_state;
  logic [1:0] num_cnt_sel;
  logic       is_dec;

  assign is_dec = (sts.op == OP_DEC);

  // where the integer digits start once any sign is out
  always_comb begin
    if (is_dec && sts.pad_nz) begin
      num_state   = S_PAD;
      num_cnt_sel = CNT_PAD;
    end else begin
      num_state   = S_DIG;
      num_cnt_sel = CNT_DIG;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.op) inside
          OP_DEC, OP_FIX: begin
            cmd.conv_start = 1'b1;
            cmd.conv_src   = CONV_SRC_INT;
            state_nxt      = S_CONV;
          end
          OP_HEX: begin
            cmd.cnt_load = 1'b1;
            cmd.cnt_sel  = CNT_HEX;
            state_nxt    = S_HEX;
          end
          default: state_nxt = S_ONE;
        endcase
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_last) state_nxt = S_NUM;
      end
      S_NUM: begin
        if (sts.neg) begin
          state_nxt = S_SIGN;
        end else begin
          cmd.cnt_load = 1'b1;
          cmd.cnt_sel  = num_cnt_sel;
          state_nxt    = num_state;
        end
      end
      S_SIGN: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.char_sel = CH_SIGN;
          cmd.cnt_load = 1'b1;
          cmd.cnt_sel  = num_cnt_sel;
          state_nxt    = num_state;
        end
      end
      S_PAD: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.char_sel = CH_ZERO;
          cmd.cnt_dec  = 1'b1;
          if (sts.cnt_one) begin
            cmd.cnt_load = 1'b1;
            cmd.cnt_sel  = CNT_DIG;
            state_nxt    = S_DIG;
          end
        end
      end
      S_DIG: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.char_sel = CH_DIGIT;
          cmd.last     = is_dec && sts.cnt_one;
          cmd.cnt_dec  = 1'b1;
          if (sts.cnt_one) state_nxt = is_dec ? S_IDLE : S_DOT;
        end
      end
      S_DOT: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.char_sel   = CH_DOT;
          cmd.conv_start = 1'b1;
          cmd.conv_src   = CONV_SRC_FRAC;
          state_nxt      = S_CONV2;
        end
      end
      S_CONV2: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_last) begin
          cmd.cnt_load = 1'b1;
          cmd.cnt_sel  = CNT_FRAC;
          state_nxt    = S_FRAC;
        end
      end
      S_FRAC: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.char_sel   = CH_FRAC;
          cmd.last       = sts.cnt_one;
          cmd.cnt_dec    = 1'b1;
          cmd.frac_shift = 1'b1;
          if (sts.cnt_one) state_nxt = S_IDLE;
        end
      end
      S_HEX: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.char_sel = CH_HEX;
          cmd.last     = sts.cnt_one;
          cmd.cnt_dec  = 1'b1;
          if (sts.cnt_one) state_nxt = S_IDLE;
        end
      end
      S_ONE: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.char_sel = (sts.op == OP_CHR) ? CH_BYTE : CH_EMPTY;
          cmd.last     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  `ITF_ASSERT_NOW(a_emit_needs_slot, cmd.emit, sts.out_free,
    "character emitted into an occupied output register")
  `ITF_ASSERT_NEXT(a_last_ends_item, cmd.emit && cmd.last, state_r == S_IDLE,
    "sequencer not idle after final character")
  `ITF_ASSERT_NOW(a_step_not_emit, cmd.conv_step, !cmd.emit && !in_ready,
    "conversion step overlaps emission or idle")

endmodule

`default_nettype wire

FILE: rtl/core/integer_to_text_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_text_formatter_core
// Formats a signed 32-bit value as ASCII text, one character per transaction.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_ready is high only while the sequencer is
// idle. Decimal and the integer part of fixed 16.16 go through a 32-step
// shift-add-3 converter, and the fraction of fixed is converted by a second
// pass; hex, character and unknown formats skip the converter. The last
// character sits in the output register while the next item is already
// accepted. Precision saturates at MAX_PRECISION (8 to 62) for decimal
// padding.
`default_nettype none

module integer_to_text_formatter_core
  import itf_pkg::*;
#(
  parameter int MAX_PRECISION = 32
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire itf_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output itf_out_t     out_data
);

  itf_cmd_t cmd;
  itf_sts_t sts;

  itf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  itf_dpath #(
    .MAX_PRECISION (MAX_PRECISION)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
